[rtl/gii_pkg.sv]
// Shared constants, register codes and the gray conversion for the gray integral image block.
package gii_pkg;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int RGB_W     = 8;
	localparam int GRAY_W    = 8;
	localparam int ROWSUM_W  = 18;
	localparam int SUM_W     = 28;

	localparam int S_TDATA_W = 3 * RGB_W;
	localparam int M_TDATA_W = ((GRAY_W + SUM_W + 7) / 8) * 8;

	localparam int DEFAULT_MAX_WIDTH  = 1024;
	localparam int DEFAULT_MAX_HEIGHT = 1024;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	// Q0.8 forms of 0.21, 0.72 and 0.07; the weights sum to 256 so the result fits 8 bits.
	localparam logic [15:0] WEIGHT_R = 16'd54;
	localparam logic [15:0] WEIGHT_G = 16'd184;
	localparam logic [15:0] WEIGHT_B = 16'd18;

	function automatic logic [GRAY_W-1:0] gray_of(input logic [RGB_W-1:0] r,
		input logic [RGB_W-1:0] g, input logic [RGB_W-1:0] b);
		logic [15:0] acc;
		acc = WEIGHT_R * 16'(r) + WEIGHT_G * 16'(g) + WEIGHT_B * 16'(b);
		return acc[15:8];
	endfunction

endpackage

[rtl/gii_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module gii_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/gray_integral_image_top.sv]
// Top level of the gray conversion and integral image block.
//
// RGB pixels enter in raster order and each leaves as a gray value with its summed-area
// value; tlast marks the final pixel of the frame. The block takes one pixel every clock
// cycle while the output is not stalled. Each pixel passes through the operand stage, the
// gray and row-sum stage and the output register before its result appears on the output.
// The rate is set by the line buffer of previous-row integrals: one RAM read when a pixel
// is taken and one write when its integral is formed, with forwarding from the two most
// recent writes, so any width down to one pixel runs at full rate. The buffer needs no
// clearing after reset; the first row of a frame ignores what it reads there. Width and
// height of 0 act as 1 and values above the maximum act as the maximum; write them only
// while the block is idle.
module gray_integral_image_top #(
	parameter int MAX_WIDTH  = gii_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = gii_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gii_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gii_pkg::CFG_W-1:0]        cfg_data,
	// pixel input
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [gii_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	// result output
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [gii_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // gray [7:0], integral_sum [35:8], zeros above
	output logic                             m_axis_tlast   // frame_last
);

	import gii_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int HW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

	// configuration
	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [WW-1:0] w_ext, w_eff;
	logic [HW-1:0] h_ext, h_eff;

	always_comb begin
		w_ext = WW'(image_width_q);
		h_ext = HW'(image_height_q);
		if (w_ext == '0)                 w_eff = WW'(1);
		else if (w_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else                             w_eff = w_ext;
		if (h_ext == '0)                  h_eff = HW'(1);
		else if (h_ext > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
		else                              h_eff = h_ext;
	end

	// pipeline control
	logic s1_v_q, s2_v_q, out_v_q;
	logic out_adv, s2_free, s1_free;
	logic s_accept, s1_adv, s2_adv;

	assign out_adv       = !out_v_q || m_axis_tready;
	assign s2_free       = !s2_v_q || out_adv;
	assign s1_free       = !s1_v_q || s2_free;
	assign s_axis_tready = s1_free;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign s1_adv        = s1_v_q && s2_free;
	assign s2_adv        = s2_v_q && out_adv;
	assign m_axis_tvalid = out_v_q;

	// raster position of the next pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          row_end, frame_end;

	assign row_end   = WW'(col_q) >= (w_eff - WW'(1));
	assign frame_end = row_end && (HW'(row_q) >= (h_eff - HW'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: operands, while the line buffer is read
	logic [RGB_W-1:0] red_s1, green_s1, blue_s1;
	logic [CW-1:0]    col_s1;
	logic             first_row_s1, row_end_s1, last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_free) begin
			s1_v_q <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			red_s1       <= s_axis_tdata[RGB_W-1:0];
			green_s1     <= s_axis_tdata[2*RGB_W-1:RGB_W];
			blue_s1      <= s_axis_tdata[3*RGB_W-1:2*RGB_W];
			col_s1       <= col_q;
			first_row_s1 <= (row_q == '0);
			row_end_s1   <= row_end;
			last_s1      <= frame_end;
		end
	end

	// line buffer of the previous row's integrals
	logic [SUM_W-1:0] ram_rdata;
	logic [SUM_W-1:0] integral;
	logic [CW-1:0]    col_s2;

	gii_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (s2_adv),
		.wr_addr (col_s2),
		.wr_data (integral),
		.rd_en   (s_accept),
		.rd_addr (col_q),
		.rd_data (ram_rdata)
	);

	// Most recent write, for a read that met a write to the same column on one edge.
	logic             lw_v_q;
	logic [CW-1:0]    lw_col_q;
	logic [SUM_W-1:0] lw_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_v_q <= 1'b0;
		end else if (s2_adv) begin
			lw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			lw_col_q  <= col_s2;
			lw_data_q <= integral;
		end
	end

	// stage 2: gray value, running row sum and the integral from the row above
	logic [GRAY_W-1:0]   gray_s1;
	logic [ROWSUM_W-1:0] row_sum_q, row_sum_next;
	logic [SUM_W-1:0]    above_s1;

	assign gray_s1      = gray_of(red_s1, green_s1, blue_s1);
	assign row_sum_next = row_sum_q + ROWSUM_W'(gray_s1);

	always_comb begin
		if (first_row_s1)                          above_s1 = '0;
		else if (s2_v_q && col_s2 == col_s1)       above_s1 = integral;
		else if (lw_v_q && lw_col_q == col_s1)     above_s1 = lw_data_q;
		else                                       above_s1 = ram_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
		end else if (s1_adv) begin
			row_sum_q <= row_end_s1 ? '0 : row_sum_next;
		end
	end

	logic [GRAY_W-1:0]   gray_s2;
	logic [ROWSUM_W-1:0] row_sum_s2;
	logic [SUM_W-1:0]    above_s2;
	logic                last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s2_free) begin
			s2_v_q <= s1_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			gray_s2    <= gray_s1;
			row_sum_s2 <= row_sum_next;
			above_s2   <= above_s1;
			col_s2     <= col_s1;
			last_s2    <= last_s1;
		end
	end

	assign integral = SUM_W'(row_sum_s2) + above_s2;

	// output register
	logic [GRAY_W-1:0] gray_q;
	logic [SUM_W-1:0]  sum_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_adv) begin
			out_v_q <= s2_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			gray_q <= gray_s2;
			sum_q  <= integral;
			last_q <= last_s2;
		end
	end

	assign m_axis_tdata = M_TDATA_W'({sum_q, gray_q});
	assign m_axis_tlast = last_q;

`ifndef SYNTH
	// A beat leaving stage 1 always lands in stage 2.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> s2_v_q)
		else $error("stage 1 beat lost before stage 2");

	// A beat leaving stage 2 always lands in the output register.
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s2_adv |=> out_v_q)
		else $error("stage 2 beat lost before output");

	// The end of a row returns the column to zero.
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && row_end) |=> (col_q == '0))
		else $error("column not cleared at end of row");

	// The end of a frame returns both counters to zero.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && frame_end) |=> (col_q == '0 && row_q == '0))
		else $error("position not cleared at end of frame");
`endif

endmodule

[bench/tb.sv]
// Self-checking testbench for the gray conversion and integral image block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gii_pkg::*;

	localparam int RANDOM_PIXELS  = 1650;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_PRINTS     = 50;

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic [SUM_W-1:0]  sum;
		logic              last;
	} pixel_result_t;

	typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		logic [RGB_W-1:0]     red;
		logic [RGB_W-1:0]     green;
		logic [RGB_W-1:0]     blue;
		logic                 typed;
		pixel_result_t        want;
	} directed_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_W-1:0]      cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tlast;

	// Predictor state, mirroring the block's registers and line buffer.
	logic [CFG_W-1:0]    width_setting  = WIDTH_RESET;
	logic [CFG_W-1:0]    height_setting = HEIGHT_RESET;
	logic [9:0]          next_col       = '0;
	logic [9:0]          next_row       = '0;
	logic [ROWSUM_W-1:0] row_gray_sum   = '0;
	logic [SUM_W-1:0]    upper_row_sums [DEFAULT_MAX_WIDTH];

	pixel_result_t expected_results [$];
	int            mismatches      = 0;
	int            quiet_cycles    = 0;
	int            sender_gap_pct  = 0;
	int            sink_stall_pct  = 0;

	gray_integral_image_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // red [7:0], green [15:8], blue [23:16]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // gray [7:0], integral_sum [35:8], zeros above
		.m_axis_tlast  (m_axis_tlast)   // frame_last
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [CFG_W-1:0] effective_dim(input logic [CFG_W-1:0] v);
		if (v == '0) return CFG_W'(1);
		if (v > CFG_W'(DEFAULT_MAX_WIDTH)) return CFG_W'(DEFAULT_MAX_WIDTH);
		return v;
	endfunction

	// Integral is the running row sum plus the integral of the pixel above.
	task automatic predict_pixel(input logic [RGB_W-1:0] r, input logic [RGB_W-1:0] g,
		input logic [RGB_W-1:0] b, output pixel_result_t res);
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [15:0]      acc;
		logic [SUM_W-1:0] above;
		logic             row_end;
		logic             frame_end;
		w = effective_dim(width_setting);
		h = effective_dim(height_setting);
		acc = 16'd54 * 16'(r) + 16'd184 * 16'(g) + 16'd18 * 16'(b);
		res.gray = acc[15:8];
		row_gray_sum = row_gray_sum + ROWSUM_W'(res.gray);
		above = (next_row != '0) ? upper_row_sums[next_col] : '0;
		res.sum = SUM_W'(row_gray_sum) + above;
		upper_row_sums[next_col] = res.sum;
		row_end = CFG_W'(next_col) >= w - CFG_W'(1);
		frame_end = row_end && (CFG_W'(next_row) >= h - CFG_W'(1));
		res.last = frame_end;
		if (row_end) begin
			next_col = '0;
			row_gray_sum = '0;
			next_row = frame_end ? '0 : next_row + 10'd1;
		end else begin
			next_col = next_col + 10'd1;
		end
	endtask

	task automatic set_idle_phase(input int phase);
		case (phase)
			0: begin
				sender_gap_pct = 9;
				sink_stall_pct = 56;
			end
			1: begin
				sender_gap_pct = 56;
				sink_stall_pct = 9;
			end
			default: begin
				sender_gap_pct = 0;
				sink_stall_pct = 0;
			end
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_pixel(input logic [RGB_W-1:0] r, input logic [RGB_W-1:0] g,
		input logic [RGB_W-1:0] b, input logic typed, input pixel_result_t typed_res);
		pixel_result_t res;
		while ($urandom_range(99) < sender_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		predict_pixel(r, g, b, res);
		if (typed)
			res = typed_res;
		expected_results.push_back(res);
		s_axis_tdata  <= {b, g, r};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Registers change only once the pipeline has emptied.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_setting = val;
		else if (idx == REG_IMAGE_HEIGHT)
			height_setting = val;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want,
				$time);
	endtask

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin : check_results
		pixel_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result beat", 32'(m_axis_tdata[GRAY_W+SUM_W-1:0]), 0);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[GRAY_W-1:0] !== want.gray)
					report_mismatch("gray", 32'(m_axis_tdata[GRAY_W-1:0]), 32'(want.gray));
				if (m_axis_tdata[GRAY_W+SUM_W-1:GRAY_W] !== want.sum)
					report_mismatch("integral_sum", 32'(m_axis_tdata[GRAY_W+SUM_W-1:GRAY_W]),
						32'(want.sum));
				if (m_axis_tlast !== want.last)
					report_mismatch("frame_last", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		directed_row_t    steps [28];
		pixel_result_t    no_result;
		logic [CFG_W-1:0] new_w;
		logic [CFG_W-1:0] new_h;
		logic [RGB_W-1:0] r;
		logic [RGB_W-1:0] g;
		logic [RGB_W-1:0] b;
		int               random_pixels;
		int               wide_frames;
		int               pick;
		int               eff_w;
		int               eff_h;
		int               mid_at;
		int               frame_count;

		no_result = '0;
		random_pixels = 0;
		wide_frames = 0;
		steps = '{
			// Default 640 x 480 frame straight after reset.
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd255, 8'd255, 8'd255, 1'b1,
				'{8'd255, 28'd255, 1'b0}},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1,
				'{8'd0, 28'd255, 1'b0}},
			// Width of zero mid-row: the row ends on the next pixel.
			'{ROW_REG, REG_IMAGE_WIDTH, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd255, 8'd0, 8'd0, 1'b0, '0},
			// Height of zero on the second row: the frame ends with this row.
			'{ROW_REG, REG_IMAGE_HEIGHT, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd0, 8'd255, 8'd0, 1'b0, '0},
			// One-pixel frames.
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd0, 8'd0, 8'd255, 1'b1,
				'{8'd17, 28'd17, 1'b1}},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd255, 8'd255, 8'd255, 1'b1,
				'{8'd255, 28'd255, 1'b1}},
			// Register maxima act as the largest frame.
			'{ROW_REG, REG_IMAGE_WIDTH, 11'd2047, 8'd0, 8'd0, 8'd0, 1'b0, '0},
			'{ROW_REG, REG_IMAGE_HEIGHT, 11'd2047, 8'd0, 8'd0, 8'd0, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd1, 8'd2, 8'd3, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd128, 8'd128, 8'd128, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd200, 8'd100, 8'd50, 1'b0, '0},
			// Width shrinks below the current column.
			'{ROW_REG, REG_IMAGE_WIDTH, 11'd3, 8'd0, 8'd0, 8'd0, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd7, 8'd8, 8'd9, 1'b0, '0},
			'{ROW_REG, REG_IMAGE_HEIGHT, 11'd2, 8'd0, 8'd0, 8'd0, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd90, 8'd180, 8'd45, 1'b0, '0},
			// A plain 4 x 2 frame.
			'{ROW_REG, REG_IMAGE_WIDTH, 11'd4, 8'd0, 8'd0, 8'd0, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd255, 8'd0, 8'd255, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd0, 8'd255, 8'd255, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd255, 8'd255, 8'd0, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd17, 8'd34, 8'd51, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd170, 8'd85, 8'd240, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd1, 8'd1, 8'd1, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd254, 8'd254, 8'd254, 1'b0, '0},
			'{ROW_PIXEL, REG_IMAGE_WIDTH, 11'd0, 8'd128, 8'd64, 8'd32, 1'b0, '0}
		};

		set_idle_phase(0);
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == ROW_REG)
				write_reg(steps[i].reg_idx, steps[i].reg_val);
			else
				send_pixel(steps[i].red, steps[i].green, steps[i].blue, steps[i].typed,
					steps[i].want);
		end

		// Whole frames with fresh dimensions, now and then resized part way through.
		while (random_pixels < RANDOM_PIXELS) begin
			set_idle_phase(random_pixels * 3 / RANDOM_PIXELS);
			pick = $urandom_range(99);
			if (pick < 3 && wide_frames < 2 && random_pixels < 600) begin
				if (wide_frames == 0) begin
					new_w = CFG_W'($urandom_range(1024, 2047));
					new_h = CFG_W'($urandom_range(0, 1));
				end else begin
					new_w = CFG_W'($urandom_range(0, 1));
					new_h = CFG_W'($urandom_range(1024, 2047));
				end
				wide_frames++;
			end else if (pick < 10) begin
				new_w = CFG_W'($urandom_range(0, 3));
				new_h = CFG_W'($urandom_range(0, 3));
			end else if (pick < 35) begin
				new_w = CFG_W'($urandom_range(1, 64));
				new_h = CFG_W'($urandom_range(1, 4));
			end else begin
				new_w = CFG_W'($urandom_range(1, 12));
				new_h = CFG_W'($urandom_range(1, 8));
			end
			write_reg(REG_IMAGE_WIDTH, new_w);
			write_reg(REG_IMAGE_HEIGHT, new_h);

			eff_w = int'(effective_dim(new_w));
			eff_h = int'(effective_dim(new_h));
			mid_at = 0;
			if ($urandom_range(9) == 0 && eff_w <= 64 && eff_w * eff_h > 1)
				mid_at = $urandom_range(1, eff_w * eff_h - 1);
			frame_count = 0;
			do begin
				if ($urandom_range(9) == 0) begin
					r = $urandom_range(1) ? 8'd255 : 8'd0;
					g = r;
					b = r;
				end else begin
					r = RGB_W'($urandom_range(255));
					g = RGB_W'($urandom_range(255));
					b = RGB_W'($urandom_range(255));
				end
				send_pixel(r, g, b, 1'b0, no_result);
				random_pixels++;
				frame_count++;
				// Only shrinking the width keeps every line-buffer read on a written entry.
				if (frame_count == mid_at) begin
					if ($urandom_range(1))
						write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, eff_w)));
					else
						write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 8)));
				end
			end while (next_col != '0 || next_row != '0);
		end

		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
